FILE: rtl/las_pkg.sv
// Package for the LED animation sequencer: command and pattern codes,
// channel word types and fixed constants. No dependencies.
package las_pkg;

	localparam int LEVEL_W    = 5;
	localparam int OUT_LAMP_W = 10;
	localparam int RAND_W     = 32;
	localparam int ELAPSED_W  = 32;

	localparam logic [LEVEL_W-1:0]   MAX_LEVEL_RESET = 5'd31;
	localparam logic [ELAPSED_W-1:0] PERIOD_RESET_MS = 32'd128;
	localparam logic [2:0]           DROP_LAST       = 3'd4;

	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_PRESS_BACK = 3'd1,
		CMD_PRESS_FWD  = 3'd2,
		CMD_PRESS_MODE = 3'd3,
		CMD_LONG_BACK  = 3'd4,
		CMD_LONG_FWD   = 3'd5,
		CMD_LONG_MODE  = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		PAT_CHASE        = 3'd0,
		PAT_BOUNCE       = 3'd1,
		PAT_TOGGLE_CHASE = 3'd2,
		PAT_TOGGLE_BNC   = 3'd3,
		PAT_ALT_PAIRS    = 3'd4,
		PAT_CROSSROADS   = 3'd5,
		PAT_NOISE        = 3'd6,
		PAT_RAINDROPS    = 3'd7
	} pat_t;

	typedef struct packed {
		cmd_t              command;
		logic [RAND_W-1:0] random_word;
	} event_word_t;

	typedef struct packed {
		logic [OUT_LAMP_W-1:0] led_pattern;
		logic                  animated_mode;
		logic [2:0]            pattern_index;
		logic                  moving_backward;
	} display_word_t;

endpackage

FILE: rtl/las_stream_if.sv
// Valid/ready channel carrying one word of a chosen type.
// Used with the word types of las_pkg.
interface las_stream_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/led_animation_sequencer.sv
// LED animation sequencer top level: input register, pattern step logic and
// result register. Uses las_pkg, las_stream_if and las_lamp_mod.
//
//   channel    dir  word            handshake
//   events     in   event_word_t    valid/ready
//   display    out  display_word_t  valid/ready
//   cfg        in   max_level       cfg_we, no back-pressure
//
// One word per cycle sustained while display is not stalled; a result is offered once
// its event has passed the input register and the state update into the result register.
// Reset clears the state to lamp 0 lit, manual, forward, pattern 0, level
// START_LEVEL, 128 ms period, max_level 31.
// A stalled result holds the input register; events stay accepted while it is free.
module led_animation_sequencer #(
	parameter int LAMP_COUNT  = 10,
	parameter int START_LEVEL = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [las_pkg::LEVEL_W-1:0]  cfg_wdata,
	las_stream_if.sink                   events,
	las_stream_if.source                 display
);
	import las_pkg::*;

	localparam int IW   = $clog2(LAMP_COUNT);
	localparam int POSW = $clog2(LAMP_COUNT + 1);
	localparam int PW   = IW + 3;

	localparam logic signed [PW-1:0] ZERO_S = PW'(0);
	localparam logic signed [PW-1:0] ONE_S  = PW'(1);
	localparam logic signed [PW-1:0] TWO_S  = PW'(2);
	localparam logic signed [PW-1:0] N_S    = PW'(LAMP_COUNT);
	localparam logic signed [PW-1:0] N2_S   = PW'(2 * LAMP_COUNT);

	function automatic logic [LAMP_COUNT-1:0] lamp_put(input logic [LAMP_COUNT-1:0] v,
			input logic signed [PW-1:0] i, input logic on);
		logic [LAMP_COUNT-1:0] r;
		r = v;
		if (i >= ZERO_S && i < N_S) begin
			r[i[IW-1:0]] = on;
		end
		return r;
	endfunction

	function automatic logic [LAMP_COUNT-1:0] lamp_flip(input logic [LAMP_COUNT-1:0] v,
			input logic signed [PW-1:0] i);
		logic [LAMP_COUNT-1:0] r;
		r = v;
		if (i >= ZERO_S && i < N_S) begin
			r[i[IW-1:0]] = ~v[i[IW-1:0]];
		end
		return r;
	endfunction

	function automatic logic signed [PW-1:0] move_wrap(input logic signed [PW-1:0] p,
			input logic bk);
		logic signed [PW-1:0] q;
		if (bk) begin
			q = p - ONE_S;
			if (q < ZERO_S) begin
				q = q + N_S;
			end
		end else begin
			q = p + ONE_S;
			if (q >= N_S) begin
				q = q - N_S;
			end
		end
		return q;
	endfunction

	// returns {new direction, new position}
	function automatic logic [PW:0] move_bounce(input logic signed [PW-1:0] p,
			input logic bk, input logic tog);
		logic signed [PW-1:0] q;
		logic                 b;
		b = bk;
		if (bk) begin
			q = p - ONE_S;
			if (q < ZERO_S) begin
				q = tog ? -q - ONE_S : -q;
				b = 1'b0;
			end
		end else begin
			q = p + ONE_S;
			if (q >= N_S) begin
				q = tog ? N2_S - q - ONE_S : N2_S - q - TWO_S;
				b = 1'b1;
			end
		end
		return {b, q};
	endfunction

	// input register
	logic          valid_s1;
	cmd_t          cmd_s1;
	logic [IW-1:0] ridx_s1;
	logic [IW-1:0] ridx;
	logic          adv;

	// state
	logic [LAMP_COUNT-1:0] lamp_q;
	logic [POSW-1:0]       pos_q;
	logic                  bk_q;
	logic                  auto_q;
	pat_t                  sel_q;
	logic [LEVEL_W-1:0]    lvl_q;
	logic [ELAPSED_W-1:0]  per_q;
	logic [ELAPSED_W-1:0]  el_q;
	logic [2:0]            ds_q;
	logic [LEVEL_W-1:0]    max_q;

	// result register
	logic          out_valid_q;
	display_word_t out_q;

	// next state
	logic [LAMP_COUNT-1:0] lb_n;
	logic signed [PW-1:0]  p;
	logic [PW:0]           bnc;
	logic                  bk_n;
	logic                  auto_n;
	pat_t                  sel_n;
	logic [LEVEL_W-1:0]    lvl_n;
	logic [ELAPSED_W-1:0]  per_n;
	logic [ELAPSED_W-1:0]  el_n;
	logic [2:0]            ds_n;
	logic                  do_step;
	logic                  do_level;
	logic [LEVEL_W:0]      lvl_req;
	logic [LEVEL_W-1:0]    top;
	logic [OUT_LAMP_W-1:0] led_n;

	las_lamp_mod #(.LAMP_COUNT(LAMP_COUNT)) u_lamp_mod (
		.word (events.data.random_word),
		.idx  (ridx)
	);

	assign adv          = valid_s1 && (!out_valid_q || display.ready);
	assign events.ready = !valid_s1 || adv;
	assign display.valid = out_valid_q;
	assign display.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			cmd_s1  <= events.data.command;
			ridx_s1 <= ridx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_LEVEL_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	always_comb begin
		lb_n     = lamp_q;
		p        = PW'(pos_q);
		bnc      = '0;
		bk_n     = bk_q;
		auto_n   = auto_q;
		sel_n    = sel_q;
		lvl_n    = lvl_q;
		per_n    = per_q;
		el_n     = el_q;
		ds_n     = ds_q;
		do_step  = 1'b0;
		do_level = 1'b0;
		lvl_req  = '0;
		top      = (max_q == '0) ? LEVEL_W'(1) : max_q;

		unique case (cmd_s1)
			CMD_TICK: begin
				el_n = el_q + ELAPSED_W'(1);
				if (auto_q && el_n > per_q) begin
					do_step = 1'b1;
					el_n    = el_n - per_q;
				end
			end
			CMD_PRESS_BACK: begin
				if (!auto_q) begin
					bk_n    = 1'b1;
					do_step = 1'b1;
				end else begin
					lvl_req  = {1'b0, lvl_q} + (LEVEL_W+1)'(1);
					do_level = 1'b1;
				end
			end
			CMD_PRESS_FWD: begin
				if (!auto_q) begin
					bk_n    = 1'b0;
					do_step = 1'b1;
				end else begin
					lvl_req  = (lvl_q == '0) ? '0 : {1'b0, lvl_q} - (LEVEL_W+1)'(1);
					do_level = 1'b1;
				end
			end
			CMD_PRESS_MODE: begin
				if (auto_q) begin
					el_n = '0;
					lb_n = '0;
					p    = ZERO_S;
					bk_n = 1'b0;
				end
				sel_n = pat_t'(sel_q + 3'd1);
			end
			CMD_LONG_BACK: bk_n = 1'b1;
			CMD_LONG_FWD:  bk_n = 1'b0;
			CMD_LONG_MODE: begin
				if (!auto_q) begin
					el_n   = '0;
					auto_n = 1'b1;
				end else begin
					auto_n = 1'b0;
				end
			end
			default: ;
		endcase

		if (do_level) begin
			if (lvl_req == '0) begin
				lvl_req = (LEVEL_W+1)'(1);
			end
			if (lvl_req > {1'b0, top}) begin
				lvl_req = {1'b0, top};
			end
			lvl_n = lvl_req[LEVEL_W-1:0];
			per_n = ELAPSED_W'(1) << lvl_n;
		end

		if (do_step) begin
			unique case (sel_q)
				PAT_CHASE: begin
					lb_n = lamp_put(lb_n, p, 1'b0);
					p    = move_wrap(p, bk_n);
					lb_n = lamp_put(lb_n, p, 1'b1);
				end
				PAT_BOUNCE: begin
					lb_n = lamp_put(lb_n, p, 1'b0);
					bnc  = move_bounce(p, bk_n, 1'b0);
					bk_n = bnc[PW];
					p    = $signed(bnc[PW-1:0]);
					lb_n = lamp_put(lb_n, p, 1'b1);
				end
				PAT_TOGGLE_CHASE: begin
					lb_n = lamp_flip(lb_n, p);
					p    = move_wrap(p, bk_n);
				end
				PAT_TOGGLE_BNC: begin
					lb_n = lamp_flip(lb_n, p);
					bnc  = move_bounce(p, bk_n, 1'b1);
					bk_n = bnc[PW];
					p    = $signed(bnc[PW-1:0]);
				end
				PAT_ALT_PAIRS: begin
					for (int i = 0; i < LAMP_COUNT / 2; i++) begin
						lb_n = lamp_put(lb_n, PW'(2 * i) + p, 1'b0);
					end
					p = p ^ ONE_S;
					for (int i = 0; i < LAMP_COUNT / 2; i++) begin
						lb_n = lamp_put(lb_n, PW'(2 * i) + p, 1'b1);
					end
				end
				PAT_CROSSROADS: begin
					lb_n = lamp_put(lb_n, p, 1'b0);
					lb_n = lamp_put(lb_n, N_S - p - ONE_S, 1'b0);
					p    = move_wrap(p, bk_n);
					lb_n = lamp_put(lb_n, p, 1'b1);
					lb_n = lamp_put(lb_n, N_S - p - ONE_S, 1'b1);
				end
				PAT_NOISE: begin
					lb_n = lamp_put(lb_n, p, 1'b0);
					p    = PW'(ridx_s1);
					lb_n = lamp_put(lb_n, p, 1'b1);
				end
				PAT_RAINDROPS: begin
					case (ds_q)
						3'd0: begin
							p    = PW'(ridx_s1);
							lb_n = lamp_put(lb_n, p, 1'b1);
						end
						3'd1: begin
							lb_n = lamp_put(lb_n, p - ONE_S, 1'b1);
							lb_n = lamp_put(lb_n, p + ONE_S, 1'b1);
						end
						3'd2: begin
							lb_n = lamp_put(lb_n, p, 1'b0);
							lb_n = lamp_put(lb_n, p - TWO_S, 1'b1);
							lb_n = lamp_put(lb_n, p + TWO_S, 1'b1);
						end
						3'd3: begin
							lb_n = lamp_put(lb_n, p - ONE_S, 1'b0);
							lb_n = lamp_put(lb_n, p + ONE_S, 1'b0);
						end
						3'd4: begin
							lb_n = lamp_put(lb_n, p - TWO_S, 1'b0);
							lb_n = lamp_put(lb_n, p + TWO_S, 1'b0);
						end
						default: ;
					endcase
					ds_n = (ds_q >= DROP_LAST) ? 3'd0 : ds_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	if (LAMP_COUNT >= OUT_LAMP_W) begin : g_led_wide
		assign led_n = lb_n[OUT_LAMP_W-1:0];
	end else begin : g_led_narrow
		assign led_n = {{(OUT_LAMP_W-LAMP_COUNT){1'b0}}, lb_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q <= LAMP_COUNT'(1);
			pos_q  <= '0;
			bk_q   <= 1'b0;
			auto_q <= 1'b0;
			sel_q  <= PAT_CHASE;
			lvl_q  <= LEVEL_W'(START_LEVEL);
			per_q  <= PERIOD_RESET_MS;
			el_q   <= '0;
			ds_q   <= '0;
		end else if (adv) begin
			lamp_q <= lb_n;
			pos_q  <= p[POSW-1:0];
			bk_q   <= bk_n;
			auto_q <= auto_n;
			sel_q  <= sel_n;
			lvl_q  <= lvl_n;
			per_q  <= per_n;
			el_q   <= el_n;
			ds_q   <= ds_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (display.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.led_pattern     <= led_n;
			out_q.animated_mode   <= auto_n;
			out_q.pattern_index   <= sel_n;
			out_q.moving_backward <= bk_n;
		end
	end

endmodule

FILE: rtl/las_lamp_mod.sv
// Reduces a 32-bit random word modulo the lamp count: two folds by 2^16 mod N,
// then a reciprocal multiply for the quotient and a subtract for the remainder. Uses las_pkg.
module las_lamp_mod #(
	parameter int LAMP_COUNT = 10
) (
	input  logic [las_pkg::RAND_W-1:0]   word,
	output logic [$clog2(LAMP_COUNT)-1:0] idx
);
	import las_pkg::*;

	localparam int          IW    = $clog2(LAMP_COUNT);
	localparam int          FOLD  = 65536 % LAMP_COUNT;
	localparam int          K     = 23;
	localparam logic [21:0] RECIP = 22'(((64'd1 << K) + LAMP_COUNT - 1) / LAMP_COUNT);

	logic [20:0] x1;
	logic [16:0] x2;
	logic [38:0] prod;
	logic [15:0] quot;
	logic [16:0] rem;

	assign x1   = 21'(word[31:16]) * 21'(FOLD) + 21'(word[15:0]);
	assign x2   = 17'(x1[20:16]) * 17'(FOLD) + 17'(x1[15:0]);
	assign prod = 39'(x2) * 39'(RECIP);
	assign quot = prod[38:K];
	assign rem  = x2 - 17'(22'(quot) * 22'(LAMP_COUNT));
	assign idx  = rem[IW-1:0];

endmodule

FILE: rtl/las_checker.sv
// Port-level assertions for the LED animation sequencer and the bind that
// attaches them to the top level. Uses las_pkg.
module las_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   ev_valid,
	input logic                   ev_ready,
	input logic                   dp_valid,
	input logic                   dp_ready,
	input las_pkg::display_word_t dp_data
);
	import las_pkg::*;

	a_dp_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dp_valid && !dp_ready |=> dp_valid)
		else $error("display word dropped while stalled");

	a_dp_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		dp_valid && !dp_ready |=> $stable(dp_data))
		else $error("display word changed while stalled");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		dp_valid && !dp_ready && $past(ev_valid && ev_ready && dp_valid && !dp_ready)
		|-> !ev_ready)
		else $error("event taken with input register full and display stalled");

	a_rise_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dp_valid) |-> $past(ev_valid && ev_ready, 2))
		else $error("display word without event two cycles before");

endmodule

bind led_animation_sequencer las_checker u_las_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.ev_valid (events.valid),
	.ev_ready (events.ready),
	.dp_valid (display.valid),
	.dp_ready (display.ready),
	.dp_data  (display.data)
);

FILE: tb/sv/tb_led_animation_sequencer.sv
`timescale 1ns / 1ps
// Testbench for led_animation_sequencer: drives event words, predicts every
// display word with its own model of the lamp row and checks them in order.
// Depends on las_pkg, las_stream_if and the block's RTL.
module tb_led_animation_sequencer;
	import las_pkg::*;

	localparam int LAMPS        = 10;
	localparam int FIRST_LEVEL  = 8;
	localparam int MAX_WAIT     = 12;
	localparam int STALL_HOLD   = 300;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [LEVEL_W-1:0] cfg_wdata;

	las_stream_if #(.word_t(event_word_t))   event_ch ();
	las_stream_if #(.word_t(display_word_t)) display_ch ();

	led_animation_sequencer #(
		.LAMP_COUNT(LAMPS),
		.START_LEVEL(FIRST_LEVEL)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.events(event_ch.sink),
		.display(display_ch.source)
	);

	logic [LAMPS-1:0]     lamps_m;
	int                   pos_m;
	logic                 back_m;
	logic                 auto_m;
	pat_t                 pat_m;
	logic [LEVEL_W-1:0]   level_m;
	logic [LEVEL_W-1:0]   max_level_m;
	logic [ELAPSED_W-1:0] period_m;
	logic [ELAPSED_W-1:0] elapsed_m;
	logic [2:0]           drop_m;

	display_word_t display_due[$];
	int            mismatches    = 0;
	int            words_checked = 0;
	int            events_sent   = 0;
	int            lamp_steps    = 0;
	int            level_writes  = 0;
	logic [7:0]    patterns_stepped = '0;
	bit            hold_display  = 1'b0;
	int            tx_run        = 0;
	int            rx_run        = 0;

	function automatic int draw_wait(inout int run);
		if (run > 0) begin
			run--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			run = $urandom_range(10, 40);
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void lamp_set(int i, logic on);
		if (i >= 0 && i < LAMPS)
			lamps_m[i] = on;
	endfunction

	function automatic void lamp_toggle(int i);
		if (i >= 0 && i < LAMPS)
			lamps_m[i] = ~lamps_m[i];
	endfunction

	function automatic void move_wrap();
		if (back_m) begin
			pos_m--;
			if (pos_m < 0)
				pos_m += LAMPS;
		end else begin
			pos_m++;
			if (pos_m >= LAMPS)
				pos_m -= LAMPS;
		end
	endfunction

	function automatic void move_bounce(bit toggling);
		if (back_m) begin
			pos_m--;
			if (pos_m < 0) begin
				pos_m  = toggling ? -pos_m - 1 : -pos_m;
				back_m = 1'b0;
			end
		end else begin
			pos_m++;
			if (pos_m >= LAMPS) begin
				pos_m  = toggling ? 2 * LAMPS - pos_m - 1 : 2 * LAMPS - pos_m - 2;
				back_m = 1'b1;
			end
		end
	endfunction

	function automatic void step_lamps(logic [RAND_W-1:0] rw);
		int i;
		lamp_steps++;
		patterns_stepped[pat_m] = 1'b1;
		case (pat_m)
			PAT_CHASE: begin
				lamp_set(pos_m, 1'b0);
				move_wrap();
				lamp_set(pos_m, 1'b1);
			end
			PAT_BOUNCE: begin
				lamp_set(pos_m, 1'b0);
				move_bounce(1'b0);
				lamp_set(pos_m, 1'b1);
			end
			PAT_TOGGLE_CHASE: begin
				lamp_toggle(pos_m);
				move_wrap();
			end
			PAT_TOGGLE_BNC: begin
				lamp_toggle(pos_m);
				move_bounce(1'b1);
			end
			PAT_ALT_PAIRS: begin
				for (i = 0; i < LAMPS / 2; i++)
					lamp_set(i * 2 + pos_m, 1'b0);
				pos_m = pos_m ^ 1;
				for (i = 0; i < LAMPS / 2; i++)
					lamp_set(i * 2 + pos_m, 1'b1);
			end
			PAT_CROSSROADS: begin
				lamp_set(pos_m, 1'b0);
				lamp_set(LAMPS - pos_m - 1, 1'b0);
				move_wrap();
				lamp_set(pos_m, 1'b1);
				lamp_set(LAMPS - pos_m - 1, 1'b1);
			end
			PAT_NOISE: begin
				lamp_set(pos_m, 1'b0);
				pos_m = int'(rw % RAND_W'(LAMPS));
				lamp_set(pos_m, 1'b1);
			end
			default: begin
				case (drop_m)
					3'd0: begin
						pos_m = int'(rw % RAND_W'(LAMPS));
						lamp_set(pos_m, 1'b1);
					end
					3'd1: begin
						lamp_set(pos_m - 1, 1'b1);
						lamp_set(pos_m + 1, 1'b1);
					end
					3'd2: begin
						lamp_set(pos_m, 1'b0);
						lamp_set(pos_m - 2, 1'b1);
						lamp_set(pos_m + 2, 1'b1);
					end
					3'd3: begin
						lamp_set(pos_m - 1, 1'b0);
						lamp_set(pos_m + 1, 1'b0);
					end
					3'd4: begin
						lamp_set(pos_m - 2, 1'b0);
						lamp_set(pos_m + 2, 1'b0);
					end
					default: ;
				endcase
				drop_m = (drop_m >= DROP_LAST) ? 3'd0 : drop_m + 3'd1;
			end
		endcase
	endfunction

	function automatic void set_level(int lvl);
		int top;
		top = (max_level_m == '0) ? 1 : int'(max_level_m);
		if (lvl < 1)
			lvl = 1;
		if (lvl > top)
			lvl = top;
		level_m  = LEVEL_W'(lvl);
		period_m = ELAPSED_W'(1) << lvl;
	endfunction

	function automatic void reset_model();
		max_level_m = MAX_LEVEL_RESET;
		lamps_m     = LAMPS'(1);
		pos_m       = 0;
		back_m      = 1'b0;
		auto_m      = 1'b0;
		pat_m       = PAT_CHASE;
		level_m     = LEVEL_W'(FIRST_LEVEL);
		period_m    = PERIOD_RESET_MS;
		elapsed_m   = '0;
		drop_m      = 3'd0;
	endfunction

	function automatic display_word_t predict_display(cmd_t c, logic [RAND_W-1:0] rw);
		display_word_t w;
		case (c)
			CMD_TICK: begin
				elapsed_m = elapsed_m + 1'b1;
				if (auto_m && elapsed_m > period_m) begin
					step_lamps(rw);
					elapsed_m = elapsed_m - period_m;
				end
			end
			CMD_PRESS_BACK: begin
				if (!auto_m) begin
					back_m = 1'b1;
					step_lamps(rw);
				end else begin
					set_level(int'(level_m) + 1);
				end
			end
			CMD_PRESS_FWD: begin
				if (!auto_m) begin
					back_m = 1'b0;
					step_lamps(rw);
				end else begin
					set_level((level_m == '0) ? 0 : int'(level_m) - 1);
				end
			end
			CMD_PRESS_MODE: begin
				if (auto_m) begin
					elapsed_m = '0;
					lamps_m   = '0;
					pos_m     = 0;
					back_m    = 1'b0;
				end
				pat_m = pat_t'(3'(pat_m + 3'd1));
			end
			CMD_LONG_BACK: back_m = 1'b1;
			CMD_LONG_FWD: back_m = 1'b0;
			CMD_LONG_MODE: begin
				if (!auto_m) begin
					elapsed_m = '0;
					auto_m    = 1'b1;
				end else begin
					auto_m = 1'b0;
				end
			end
			default: ;
		endcase
		w.led_pattern     = OUT_LAMP_W'(lamps_m);
		w.animated_mode   = auto_m;
		w.pattern_index   = pat_m;
		w.moving_backward = back_m;
		return w;
	endfunction

	function automatic cmd_t pick_command(bit animated);
		int r;
		r = $urandom_range(0, 99);
		if (animated) begin
			if (r < 55) return CMD_TICK;
			if (r < 70) return CMD_PRESS_FWD;
			if (r < 80) return CMD_PRESS_BACK;
			if (r < 86) return CMD_PRESS_MODE;
			if (r < 90) return CMD_LONG_BACK;
			if (r < 94) return CMD_LONG_FWD;
			if (r < 97) return CMD_LONG_MODE;
		end else begin
			if (r < 20) return CMD_TICK;
			if (r < 45) return CMD_PRESS_FWD;
			if (r < 70) return CMD_PRESS_BACK;
			if (r < 80) return CMD_PRESS_MODE;
			if (r < 87) return CMD_LONG_BACK;
			if (r < 94) return CMD_LONG_FWD;
			if (r < 97) return CMD_LONG_MODE;
		end
		return cmd_t'(CMD_UNUSED);
	endfunction

	function automatic void check_display(display_word_t got);
		display_word_t want;
		if (display_due.size() == 0) begin
			if (mismatches < 10)
				$display("display word %h with nothing due", got);
			mismatches++;
			return;
		end
		want = display_due.pop_front();
		words_checked++;
		if (got.led_pattern !== want.led_pattern || got.animated_mode !== want.animated_mode ||
				got.pattern_index !== want.pattern_index ||
				got.moving_backward !== want.moving_backward) begin
			if (mismatches < 10)
				$display("word %0d: leds %b/%b auto %b/%b pattern %0d/%0d back %b/%b (exp/got)",
					words_checked, want.led_pattern, got.led_pattern, want.animated_mode,
					got.animated_mode, want.pattern_index, got.pattern_index,
					want.moving_backward, got.moving_backward);
			mismatches++;
		end
	endfunction

	task automatic send_event(input cmd_t c, input logic [RAND_W-1:0] rw, input bit no_gap = 1'b0);
		int          gap;
		event_word_t w;
		gap = no_gap ? 0 : draw_wait(tx_run);
		w.command     = c;
		w.random_word = rw;
		if (gap > 0) begin
			event_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		event_ch.valid <= 1'b1;
		event_ch.data  <= w;
		do @(posedge clk); while (!event_ch.ready);
		display_due.push_back(predict_display(c, rw));
		events_sent++;
	endtask

	task automatic settle_display();
		event_ch.valid <= 1'b0;
		while (display_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_level(input logic [LEVEL_W-1:0] v);
		settle_display();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we      <= 1'b0;
		max_level_m = v;
		level_writes++;
	endtask

	task automatic test_manual_stepping();
		send_event(cmd_t'(CMD_UNUSED), '0);
		send_event(CMD_PRESS_FWD, '0);
		send_event(CMD_PRESS_BACK, 32'hFFFF_FFFF);
		send_event(CMD_PRESS_BACK, '0);
		send_event(CMD_LONG_BACK, 32'hFFFF_FFFF);
		send_event(CMD_LONG_FWD, '0);
		send_event(CMD_TICK, '0);
		send_event(CMD_PRESS_MODE, '0);
		send_event(CMD_PRESS_BACK, '0);
		send_event(CMD_PRESS_BACK, '0);
	endtask

	task automatic test_patterns_and_modes();
		repeat (5) send_event(CMD_PRESS_MODE, $urandom);
		send_event(CMD_PRESS_FWD, 32'hFFFF_FFFF);
		send_event(CMD_PRESS_BACK, '0);
		send_event(CMD_PRESS_MODE, '0);
		send_event(CMD_PRESS_FWD, 32'hFFFF_FFFF);
		repeat (4) send_event(CMD_PRESS_FWD, $urandom);
		send_event(CMD_LONG_MODE, '0);
		send_event(CMD_PRESS_FWD, '0);
		send_event(CMD_PRESS_BACK, '0);
		send_event(CMD_TICK, 32'hFFFF_FFFF);
		send_event(CMD_PRESS_MODE, '0);
		send_event(CMD_LONG_MODE, '0);
	endtask

	task automatic test_level_limits();
		write_max_level(5'd1);
		if (!auto_m)
			send_event(CMD_LONG_MODE, $urandom);
		repeat (3) send_event(CMD_PRESS_BACK, $urandom);
		repeat (8) send_event(CMD_TICK, $urandom);
		write_max_level('0);
		repeat (2) send_event(CMD_PRESS_BACK, $urandom);
		repeat (4) send_event(CMD_TICK, $urandom);
		write_max_level(5'd31);
		repeat (32) send_event(CMD_PRESS_BACK, $urandom);
		write_max_level(5'd5);
		repeat (2) send_event(CMD_PRESS_FWD, $urandom);
		send_event(CMD_LONG_MODE, $urandom);
	endtask

	task automatic test_output_stall();
		int k;
		hold_display = 1'b1;
		for (k = 0; k < 40; k++)
			send_event(pick_command(auto_m), $urandom, 1'b1);
	endtask

	task automatic test_random_traffic(input int segments);
		int                 s;
		int                 k;
		int                 n;
		logic [LEVEL_W-1:0] lvl;
		bit                 animated;
		for (s = 0; s < segments; s++) begin
			case ($urandom_range(0, 5))
				0: lvl = '0;
				1: lvl = 5'd1;
				2: lvl = 5'd31;
				3: lvl = LEVEL_W'($urandom_range(2, 4));
				default: lvl = LEVEL_W'($urandom);
			endcase
			write_max_level(lvl);
			animated = s[0];
			if (auto_m != animated)
				send_event(CMD_LONG_MODE, $urandom);
			if (animated) begin
				n = $urandom_range(3, 10);
				for (k = 0; k < n; k++)
					send_event(CMD_PRESS_FWD, $urandom);
			end
			for (k = 0; k < 40; k++)
				send_event(pick_command(animated), $urandom);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout with %0d display words still due", display_due.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : display_sink
		int hold;
		display_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			hold = hold_display ? STALL_HOLD : draw_wait(rx_run);
			hold_display = 1'b0;
			if (hold > 0) begin
				display_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			display_ch.ready <= 1'b1;
			do @(posedge clk); while (!display_ch.valid);
			check_display(display_ch.data);
		end
	end

	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		event_ch.valid <= 1'b0;
		event_ch.data  <= '0;
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_manual_stepping();
		test_patterns_and_modes();
		test_level_limits();
		test_output_stall();
		test_random_traffic(14);
		settle_display();
		$display("Covered %0d events, %0d display words checked, %0d max_level writes",
			events_sent, words_checked, level_writes);
		$display("Predicted %0d lamp steps; patterns stepped %b", lamp_steps, patterns_stepped);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
